### design/ecpd_pkg.sv
// ----------------------------------------------------------------------------
// ecpd_pkg
// Shared types, constants and the doubling program for the EC point doubler.
// ----------------------------------------------------------------------------
package ecpd_pkg;

  localparam int unsigned FieldBitsDefault = 64;
  localparam int unsigned CfgWidth = 64;
  localparam logic [CfgWidth-1:0] ModReset = 64'hFFFF_FFFF_FFFF_FFC5;
  localparam logic [CfgWidth-1:0] CoeffReset = '0;

  typedef enum logic [0:0] {
    CFG_MODULUS = 1'b0,
    CFG_COEFF_A = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_INV = 2'd1,
    OP_ADD = 2'd2,
    OP_SUB = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    SEL_ONE   = 4'd0,
    SEL_IN_X  = 4'd1,
    SEL_IN_Y  = 4'd2,
    SEL_CFG_A = 4'd3,
    SEL_X     = 4'd4,
    SEL_Y     = 4'd5,
    SEL_A     = 4'd6,
    SEL_T     = 4'd7,
    SEL_S     = 4'd8,
    SEL_V     = 4'd9,
    SEL_U     = 4'd10
  } sel_e;

  typedef enum logic [2:0] {
    DST_X = 3'd0,
    DST_Y = 3'd1,
    DST_A = 3'd2,
    DST_T = 3'd3,
    DST_S = 3'd4,
    DST_V = 3'd5,
    DST_U = 3'd6
  } dst_e;

  typedef struct packed {
    op_e  op;
    sel_e sel_a;
    sel_e sel_b;
    dst_e dst;
  } instr_t;

  typedef struct packed {
    logic   load;
    logic   exec;
    instr_t instr;
    logic   finish;
    logic   fail;
  } cmd_t;

  typedef struct packed {
    logic p_small;
    logic mul_done;
    logic inv_done;
    logic inv_fail;
  } status_t;

  localparam int unsigned StepWidth = 4;
  localparam logic [StepWidth-1:0] LastStep = 4'd15;

  function automatic instr_t prog(input logic [StepWidth-1:0] step);
    instr_t i;
    unique case (step)
      4'd0:    i = '{OP_MUL, SEL_ONE, SEL_IN_X,  DST_X};
      4'd1:    i = '{OP_MUL, SEL_ONE, SEL_IN_Y,  DST_Y};
      4'd2:    i = '{OP_MUL, SEL_ONE, SEL_CFG_A, DST_A};
      4'd3:    i = '{OP_ADD, SEL_Y,   SEL_Y,     DST_U};
      4'd4:    i = '{OP_INV, SEL_U,   SEL_U,     DST_V};
      4'd5:    i = '{OP_MUL, SEL_X,   SEL_X,     DST_T};
      4'd6:    i = '{OP_ADD, SEL_T,   SEL_T,     DST_S};
      4'd7:    i = '{OP_ADD, SEL_S,   SEL_T,     DST_S};
      4'd8:    i = '{OP_ADD, SEL_S,   SEL_A,     DST_S};
      4'd9:    i = '{OP_MUL, SEL_S,   SEL_V,     DST_S};
      4'd10:   i = '{OP_MUL, SEL_S,   SEL_S,     DST_T};
      4'd11:   i = '{OP_ADD, SEL_X,   SEL_X,     DST_U};
      4'd12:   i = '{OP_SUB, SEL_T,   SEL_U,     DST_T};
      4'd13:   i = '{OP_SUB, SEL_X,   SEL_T,     DST_U};
      4'd14:   i = '{OP_MUL, SEL_S,   SEL_U,     DST_U};
      default: i = '{OP_SUB, SEL_U,   SEL_Y,     DST_U};
    endcase
    return i;
  endfunction

endpackage

### design/ecpd_mulmod.sv
// ----------------------------------------------------------------------------
// ecpd_mulmod
// Bit-serial modular multiplier, one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module ecpd_mulmod #(
  parameter int unsigned W = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic [W-1:0] p_i,
  output logic         done_o,
  output logic [W-1:0] r_o
);

  localparam int unsigned CW = $clog2(W + 1);
  localparam logic [CW-1:0] CntInit = CW'(W);
  localparam logic [CW-1:0] CntOne = CW'(1);

  logic [W-1:0]  a_q, b_q, r_q, r_d;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [W:0]    dbl, dbl_r, sum, sum_r;

  always_comb begin
    dbl   = {r_q, 1'b0};
    dbl_r = (dbl >= {1'b0, p_i}) ? dbl - {1'b0, p_i} : dbl;
    sum   = {1'b0, dbl_r[W-1:0]} + {1'b0, (b_q[W-1] ? a_q : '0)};
    sum_r = (sum >= {1'b0, p_i}) ? sum - {1'b0, p_i} : sum;
    r_d   = sum_r[W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntInit;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntOne;
        if (cnt_q == CntOne) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
      r_q <= '0;
    end else if (busy_q) begin
      b_q <= {b_q[W-2:0], 1'b0};
      r_q <= r_d;
    end
  end

  assign done_o = done_q;
  assign r_o    = r_q;

endmodule

### design/ecpd_inv.sv
// ----------------------------------------------------------------------------
// ecpd_inv
// Binary extended Euclid modular inverse, one reduction step per cycle.
// ----------------------------------------------------------------------------
module ecpd_inv #(
  parameter int unsigned W = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] v_i,
  input  logic [W-1:0] p_i,
  output logic         done_o,
  output logic         fail_o,
  output logic [W-1:0] r_o
);

  localparam logic [W-1:0] One = W'(1);

  logic [W-1:0] u_q, w_q, x1_q, x2_q, r_q;
  logic         busy_q, done_q, fail_q;
  logic [W:0]   x1_h, x2_h;
  logic [W-1:0] x1_m_x2, x2_m_x1;

  always_comb begin
    x1_h    = x1_q[0] ? ({1'b0, x1_q} + {1'b0, p_i}) : {1'b0, x1_q};
    x2_h    = x2_q[0] ? ({1'b0, x2_q} + {1'b0, p_i}) : {1'b0, x2_q};
    x1_m_x2 = (x1_q >= x2_q) ? x1_q - x2_q : x1_q - x2_q + p_i;
    x2_m_x1 = (x2_q >= x1_q) ? x2_q - x1_q : x2_q - x1_q + p_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      fail_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        fail_q <= 1'b0;
        if (!p_i[0]) begin
          done_q <= 1'b1;
          fail_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        if (u_q == One || w_q == One) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else if (u_q == '0 || w_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          fail_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      u_q  <= v_i;
      w_q  <= p_i;
      x1_q <= One;
      x2_q <= '0;
    end else if (busy_q) begin
      priority if (u_q == One) begin
        r_q <= x1_q;
      end else if (w_q == One) begin
        r_q <= x2_q;
      end else if (u_q == '0 || w_q == '0) begin
        r_q <= '0;
      end else if (!u_q[0]) begin
        u_q  <= u_q >> 1;
        x1_q <= x1_h[W:1];
      end else if (!w_q[0]) begin
        w_q  <= w_q >> 1;
        x2_q <= x2_h[W:1];
      end else if (u_q >= w_q) begin
        u_q  <= u_q - w_q;
        x1_q <= x1_m_x2;
      end else begin
        w_q  <= w_q - u_q;
        x2_q <= x2_m_x1;
      end
    end
  end

  assign done_o = done_q;
  assign fail_o = fail_q;
  assign r_o    = r_q;

endmodule

### design/ecpd_datapath.sv
// ----------------------------------------------------------------------------
// ecpd_datapath
// Operand registers, modular add/subtract, multiplier and inverse units.
// ----------------------------------------------------------------------------
module ecpd_datapath import ecpd_pkg::*; #(
  parameter int unsigned W = FieldBitsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cmd_t         cmd_i,
  output status_t      status_o,
  input  logic [W-1:0] p_i,
  input  logic [W-1:0] cfg_a_i,
  input  logic [W-1:0] in_x_i,
  input  logic [W-1:0] in_y_i,
  output logic [W-1:0] out_x_o,
  output logic [W-1:0] out_y_o,
  output logic         out_fail_o
);

  logic [W-1:0] in_x_q, in_y_q, x_q, y_q, a_q, t_q, s_q, v_q, u_q;
  logic [W-1:0] out_x_q, out_y_q;
  logic         out_fail_q;
  logic [W-1:0] opa, opb, alu, wdata, mul_r, inv_r;
  logic [W:0]   add_s;
  logic         mul_done, inv_done, inv_fail, wen;

  function automatic logic [W-1:0] pick(input sel_e sel, input logic [W-1:0] ix,
                                        input logic [W-1:0] iy, input logic [W-1:0] ca,
                                        input logic [W-1:0] rx, input logic [W-1:0] ry,
                                        input logic [W-1:0] ra, input logic [W-1:0] rt,
                                        input logic [W-1:0] rs, input logic [W-1:0] rv,
                                        input logic [W-1:0] ru);
    logic [W-1:0] v;
    unique case (sel)
      SEL_ONE:   v = W'(1);
      SEL_IN_X:  v = ix;
      SEL_IN_Y:  v = iy;
      SEL_CFG_A: v = ca;
      SEL_X:     v = rx;
      SEL_Y:     v = ry;
      SEL_A:     v = ra;
      SEL_T:     v = rt;
      SEL_S:     v = rs;
      SEL_V:     v = rv;
      SEL_U:     v = ru;
      default:   v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    opa   = pick(cmd_i.instr.sel_a, in_x_q, in_y_q, cfg_a_i, x_q, y_q, a_q, t_q, s_q, v_q, u_q);
    opb   = pick(cmd_i.instr.sel_b, in_x_q, in_y_q, cfg_a_i, x_q, y_q, a_q, t_q, s_q, v_q, u_q);
    add_s = {1'b0, opa} + {1'b0, opb};
    if (cmd_i.instr.op == OP_ADD) begin
      alu = (add_s >= {1'b0, p_i}) ? add_s[W-1:0] - p_i : add_s[W-1:0];
    end else begin
      alu = (opa >= opb) ? opa - opb : opa - opb + p_i;
    end
    wen   = 1'b0;
    wdata = alu;
    if (mul_done) begin
      wen   = 1'b1;
      wdata = mul_r;
    end else if (inv_done) begin
      wen   = !inv_fail;
      wdata = inv_r;
    end else if (cmd_i.exec && (cmd_i.instr.op == OP_ADD || cmd_i.instr.op == OP_SUB)) begin
      wen = 1'b1;
    end
  end

  ecpd_mulmod #(.W(W)) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.exec && cmd_i.instr.op == OP_MUL),
    .a_i    (opa),
    .b_i    (opb),
    .p_i    (p_i),
    .done_o (mul_done),
    .r_o    (mul_r)
  );

  ecpd_inv #(.W(W)) u_inv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.exec && cmd_i.instr.op == OP_INV),
    .v_i    (opa),
    .p_i    (p_i),
    .done_o (inv_done),
    .fail_o (inv_fail),
    .r_o    (inv_r)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_x_q <= in_x_i;
      in_y_q <= in_y_i;
    end
    if (wen) begin
      unique case (cmd_i.instr.dst)
        DST_X:   x_q <= wdata;
        DST_Y:   y_q <= wdata;
        DST_A:   a_q <= wdata;
        DST_T:   t_q <= wdata;
        DST_S:   s_q <= wdata;
        DST_V:   v_q <= wdata;
        default: u_q <= wdata;
      endcase
    end
    if (cmd_i.finish) begin
      out_x_q <= cmd_i.fail ? '0 : t_q;
      out_y_q <= cmd_i.fail ? '0 : u_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_fail_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_fail_q <= cmd_i.fail;
    end
  end

  assign status_o   = '{p_small: (p_i < W'(2)), mul_done: mul_done,
                        inv_done: inv_done, inv_fail: inv_fail};
  assign out_x_o    = out_x_q;
  assign out_y_o    = out_y_q;
  assign out_fail_o = out_fail_q;

endmodule

### design/ecpd_ctrl.sv
// ----------------------------------------------------------------------------
// ecpd_ctrl
// Sequencer that walks the doubling program and issues datapath commands.
// ----------------------------------------------------------------------------
module ecpd_ctrl import ecpd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy_o,
  output logic    done_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_FIN   = 4'b1000
  } state_e;

  state_e                 state_q, state_d;
  logic [StepWidth-1:0]   step_q, step_d;
  logic                   fail_q, fail_d, done_q;
  instr_t                 instr;

  assign instr = prog(step_q);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    fail_d  = fail_q;
    cmd_o   = '{load: 1'b0, exec: 1'b0, instr: instr, finish: 1'b0, fail: fail_q};
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          fail_d     = status_i.p_small;
          state_d    = status_i.p_small ? ST_FIN : ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        cmd_o.exec = 1'b1;
        if (instr.op == OP_MUL || instr.op == OP_INV) begin
          state_d = ST_WAIT;
        end else if (step_q == LastStep) begin
          state_d = ST_FIN;
        end else begin
          step_d  = step_q + 1'b1;
        end
      end
      ST_WAIT: begin
        if (status_i.inv_done && status_i.inv_fail) begin
          fail_d  = 1'b1;
          state_d = ST_FIN;
        end else if (status_i.mul_done || status_i.inv_done) begin
          if (step_q == LastStep) begin
            state_d = ST_FIN;
          end else begin
            step_d  = step_q + 1'b1;
            state_d = ST_ISSUE;
          end
        end
      end
      ST_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      fail_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      fail_q  <= fail_d;
      done_q  <= (state_q == ST_FIN);
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;

endmodule

### design/ec_point_double_prime_field_core.sv
// ----------------------------------------------------------------------------
// ec_point_double_prime_field_core
// Affine point doubling on y^2 = x^3 + a*x + b over a prime field.
//
//   channel  handshake            payload
//   input    start_i & !busy_o    point_x_i, point_y_i
//   result   done_o (one cycle)   double_x_o, double_y_o, no_inverse_o
//   config   cfg_we_i             cfg_idx_i, cfg_data_i
//
// One word runs seven multiplications in the bit-serial multiplier,
// eight add/subtract steps, one inversion and a finish step; when the
// modulus is below two the word goes straight to the finish step and is
// reported as having no inverse. Words are taken one at a time; the next
// word can be taken in the strobe cycle. Reset loads the default modulus
// and a zero coefficient. The result strobe cannot be stalled.
// ----------------------------------------------------------------------------
module ec_point_double_prime_field_core import ecpd_pkg::*; #(
  parameter int unsigned FIELD_BITS = FieldBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [63:0]         point_x_i,
  input  logic [63:0]         point_y_i,
  output logic                done_o,
  output logic [63:0]         double_x_o,
  output logic [63:0]         double_y_o,
  output logic                no_inverse_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CfgWidth-1:0] cfg_data_i
);

  localparam int unsigned W = FIELD_BITS;

  logic [CfgWidth-1:0] mod_q, coeff_q;
  cmd_t                cmd;
  status_t             status;
  logic [W-1:0]        out_x, out_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q   <= ModReset;
      coeff_q <= CoeffReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MODULUS: mod_q   <= cfg_data_i;
        default:     coeff_q <= cfg_data_i;
      endcase
    end
  end

  ecpd_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .status_i(status),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  ecpd_datapath #(.W(W)) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .status_o  (status),
    .p_i       (mod_q[W-1:0]),
    .cfg_a_i   (coeff_q[W-1:0]),
    .in_x_i    (point_x_i[W-1:0]),
    .in_y_i    (point_y_i[W-1:0]),
    .out_x_o   (out_x),
    .out_y_o   (out_y),
    .out_fail_o(no_inverse_o)
  );

  assign double_x_o = 64'(out_x);
  assign double_y_o = 64'(out_y);

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && no_inverse_o) |-> (double_x_o == '0 && double_y_o == '0))
    else $error("no-inverse result carries nonzero coordinates");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o))
    else $error("result strobe without a word in flight");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted word did not raise busy");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

endmodule
